>>> rtl/per_rate_power_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Per-rate power table engine: assertion macros
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PER_RATE_POWER_TABLE_ENGINE_DEFINES_SVH
`define PER_RATE_POWER_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PRTPE_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("prtpe: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PRTPE_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("prtpe: next-cycle check failed");

`endif

>>> rtl/prtpe_pkg.sv
// ----------------------------------------------------------------------------
// prtpe_pkg
// Types, constants and helper functions of the per-rate power table engine.
// ----------------------------------------------------------------------------
package prtpe_pkg;

	localparam int RATES_PER_ROW = 8;
	localparam int TABLE_SIZE    = 4 * RATES_PER_ROW;
	localparam int TABLE_AW      = $clog2(TABLE_SIZE);
	localparam int STORE_DEPTH   = 13;
	localparam int STORE_AW      = $clog2(STORE_DEPTH);
	localparam int CORE_BASE     = 9;
	localparam int CORES_DEF     = 4;
	localparam int COUNT_W       = 6;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 16;

	localparam logic [12:0] FREQ_BASE   = 13'd5000;
	localparam logic [12:0] EDGE_LOW40  = 13'd5250;
	localparam logic [12:0] EDGE_LOW    = 13'd5210;
	localparam logic [12:0] EDGE_MID    = 13'd5500;
	localparam logic [12:0] EDGE_HIGH   = 13'd5745;
	localparam logic [7:0]  CHAN_BAND1  = 8'd52;
	localparam logic [7:0]  CHAN_BAND2  = 8'd100;
	localparam logic [7:0]  TOP_SPACING = 8'h7f;
	localparam logic [7:0]  NO_MAX      = 8'hff;

	localparam logic [2:0] OP_STORE   = 3'd0;
	localparam logic [2:0] OP_LOAD    = 3'd1;
	localparam logic [2:0] OP_SPACING = 3'd2;
	localparam logic [2:0] OP_ADD     = 3'd3;
	localparam logic [2:0] OP_CAP     = 3'd4;
	localparam logic [2:0] OP_FLOOR   = 3'd5;
	localparam logic [2:0] OP_MAX     = 3'd6;
	localparam logic [2:0] OP_READ    = 3'd7;

	localparam logic [1:0] WIDTH_40 = 2'd1;
	localparam logic [1:0] WIDTH_80 = 2'd2;

	localparam logic CFG_CORE_MASK  = 1'b0;
	localparam logic CFG_CORE_COUNT = 1'b1;

	typedef enum logic [2:0] {
		ALU_PASS = 3'd0,
		ALU_ADD  = 3'd1,
		ALU_MIN  = 3'd2,
		ALU_MAX  = 3'd3,
		ALU_SUB2 = 3'd4
	} alu_mode_t;

	typedef struct packed {
		alu_mode_t   mode;
		logic [7:0]  a;
		logic [8:0]  b;
	} alu_req_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CORE   = 6'b000010,
		ST_TOP    = 6'b000100,
		ST_FILL   = 6'b001000,
		ST_LEGACY = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	// Entry count after a load, by channel width.
	function automatic logic [COUNT_W-1:0] count_for_width(input logic [1:0] w);
		logic [COUNT_W-1:0] c;
		case (w)
			WIDTH_80: c = COUNT_W'(4 * RATES_PER_ROW);
			WIDTH_40: c = COUNT_W'(3 * RATES_PER_ROW);
			default:  c = COUNT_W'(2 * RATES_PER_ROW);
		endcase
		return c;
	endfunction

	// OFDM rate k takes its value from this MCS20 rate.
	function automatic logic [2:0] legacy_map(input logic [2:0] k);
		logic [2:0] m;
		case (k)
			3'd4:    m = 3'd1;
			3'd5:    m = 3'd2;
			3'd6:    m = 3'd3;
			3'd7:    m = 3'd4;
			default: m = 3'd0;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/per_rate_power_table_engine.sv
// ----------------------------------------------------------------------------
// per_rate_power_table_engine
// Per-rate TX power table with a limit store, driven by one opcode per item.
// ----------------------------------------------------------------------------
// Items arrive on the s_ stream; each gives exactly one result on the m_ stream
// (power value and active entry count). The cfg channel writes core_mask
// (index 0) and core_count (index 1); it is always ready. The user must write
// it only while the engine is idle; the block itself does not enforce this.
// One item is worked at a time: s_tready is high only in the idle state.
// Work per item:
//   store word, read entry: straight to the output register
//   load: core scan, top select, 24 MCS entries, 8 OFDM copies
//   load spacing: 24 MCS entries, 8 OFDM copies
//   add, cap, floor, get max: a walk over the active entries (16, 24 or 32), none if empty.
// The single table write port and the shared ALU handle one entry per cycle.
// The result stays in the output register until the receiver takes it;
// the next item can be taken the cycle after.
// Reset clears the limit store, the table and the count, and sets core_mask
// to 1 and core_count to 4.
// ----------------------------------------------------------------------------
module per_rate_power_table_engine #(
	parameter int CORES = prtpe_pkg::CORES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// opcode[2:0], channel[10:3], width_code[12:11], ceiling[20:13],
	// adjust[29:21], bound[37:30], entry_index[42:38], slot[46:43],
	// slot_word[78:47], zero pad[79]
	input  logic [prtpe_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// value[7:0], entry_count[13:8], zero pad[15:14]
	output logic [prtpe_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic                               cfg_index,
	input  logic [3:0]                         cfg_data
);
	import prtpe_pkg::*;

	localparam int CORE_W = (CORES > 1) ? $clog2(CORES) : 1;

	// Input fields.
	logic [2:0]  in_opcode;
	logic [7:0]  in_channel;
	logic [1:0]  in_width;
	logic [7:0]  in_ceiling;
	logic [8:0]  in_adjust;
	logic [7:0]  in_bound;
	logic [4:0]  in_index;
	logic [3:0]  in_slot;
	logic [31:0] in_word;

	assign in_opcode  = s_tdata[2:0];
	assign in_channel = s_tdata[10:3];
	assign in_width   = s_tdata[12:11];
	assign in_ceiling = s_tdata[20:13];
	assign in_adjust  = s_tdata[29:21];
	assign in_bound   = s_tdata[37:30];
	assign in_index   = s_tdata[42:38];
	assign in_slot    = s_tdata[46:43];
	assign in_word    = s_tdata[78:47];

	state_t                state_q;
	logic [31:0]           store_q [STORE_DEPTH];
	logic [7:0]            tbl_q   [TABLE_SIZE];
	logic [COUNT_W-1:0]    count_q;
	logic [3:0]            mask_q;
	logic [2:0]            ccount_q;
	logic [TABLE_AW-1:0]   ptr_q;
	logic [CORE_W-1:0]     core_q;
	logic [7:0]            acc_q;
	logic [7:0]            value_q;

	logic [2:0]  op_q;
	logic [7:0]  chan_q;
	logic [1:0]  width_q;
	logic [7:0]  ceil_q;
	logic [8:0]  adj_q;
	logic [7:0]  bound_q;

	logic                accept;
	logic [12:0]         freq;
	logic [1:0]          sb;
	logic [1:0]          band;
	logic [STORE_AW-1:0] st_addr;
	logic [31:0]         st_rd;
	logic [7:0]          core_byte;
	logic [3:0]          nib;
	logic                core_sel;
	logic [TABLE_AW-1:0] tbl_ra;
	logic [7:0]          tbl_rd;
	logic                tbl_we;
	logic [7:0]          tbl_wd;
	logic                walk_last;
	logic [7:0]          maxp;
	logic [7:0]          top;
	alu_req_t            alu_req;
	logic [7:0]          alu_y;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_OUT);
	assign m_tdata   = {2'b00, count_q, value_q};
	assign cfg_ready = 1'b1;

	// Sub-band from the carrier frequency; the first edge moves at 40 MHz.
	always_comb begin
		freq = FREQ_BASE + {3'b000, chan_q, 2'b00} + {5'b00000, chan_q};
		if (freq < ((width_q == WIDTH_40) ? EDGE_LOW40 : EDGE_LOW))
			sb = 2'd0;
		else if (freq < EDGE_MID)
			sb = 2'd1;
		else if (freq < EDGE_HIGH)
			sb = 2'd2;
		else
			sb = 2'd3;
		if (chan_q < CHAN_BAND1)
			band = 2'd0;
		else if (chan_q < CHAN_BAND2)
			band = 2'd1;
		else
			band = 2'd2;
	end

	// Single read port on the limit store: core words during the scan,
	// offset words (band * 3 + row - 1) during the fill.
	always_comb begin
		if (state_q == ST_CORE)
			st_addr = STORE_AW'(CORE_BASE) + STORE_AW'(core_q);
		else
			st_addr = STORE_AW'({band, 1'b0}) + STORE_AW'(band)
				+ STORE_AW'(ptr_q[4:3]) - STORE_AW'(1);
	end

	assign st_rd     = store_q[st_addr];
	assign core_byte = 8'(st_rd >> {sb, 3'b000});
	assign nib       = 4'(st_rd >> {ptr_q[2:0], 2'b00});
	assign core_sel  = (3'(core_q) < ccount_q) && mask_q[core_q];

	// Single read port on the rate table.
	always_comb begin
		case (state_q)
			ST_LEGACY: tbl_ra = TABLE_AW'(RATES_PER_ROW) + TABLE_AW'(legacy_map(ptr_q[2:0]));
			ST_IDLE:   tbl_ra = in_index;
			default:   tbl_ra = ptr_q;
		endcase
	end

	assign tbl_rd    = tbl_q[tbl_ra];
	assign walk_last = ({1'b0, ptr_q} == count_q - COUNT_W'(1));

	always_comb begin
		maxp = (acc_q == NO_MAX) ? 8'd0 : acc_q;
		top  = (ceil_q != 8'd0 && ceil_q < maxp) ? ceil_q : maxp;
	end

	// The ST_FILL state doubles as the walk for table operations; op_q tells
	// them apart.
	always_comb begin
		alu_req.mode = ALU_PASS;
		alu_req.a    = tbl_rd;
		alu_req.b    = '0;
		case (state_q)
			ST_CORE: begin
				alu_req.mode = ALU_MIN;
				alu_req.a    = acc_q;
				alu_req.b    = {1'b0, core_byte};
			end
			ST_FILL: begin
				case (op_q)
					OP_LOAD, OP_SPACING: begin
						alu_req.mode = ALU_SUB2;
						alu_req.a    = acc_q;
						alu_req.b    = {5'b00000, nib};
					end
					OP_ADD: begin
						alu_req.mode = ALU_ADD;
						alu_req.b    = adj_q;
					end
					OP_CAP: begin
						alu_req.mode = ALU_MIN;
						alu_req.b    = {1'b0, bound_q};
					end
					OP_FLOOR: begin
						alu_req.mode = ALU_MAX;
						alu_req.b    = {1'b0, bound_q};
					end
					OP_MAX: begin
						alu_req.mode = ALU_MAX;
						alu_req.b    = {1'b0, acc_q};
					end
					default: alu_req.mode = ALU_PASS;
				endcase
			end
			default: alu_req.mode = ALU_PASS;
		endcase
	end

	prtpe_alu u_alu (
		.req (alu_req),
		.y   (alu_y)
	);

	// Table write data: fill rows past the count are cleared.
	always_comb begin
		tbl_we = 1'b0;
		tbl_wd = alu_y;
		case (state_q)
			ST_FILL: begin
				if (op_q == OP_LOAD || op_q == OP_SPACING) begin
					tbl_we = 1'b1;
					tbl_wd = ({1'b0, ptr_q} < count_q) ? alu_y : 8'd0;
				end else begin
					tbl_we = (op_q != OP_MAX);
				end
			end
			ST_LEGACY: begin
				tbl_we = 1'b1;
				tbl_wd = tbl_rd;
			end
			default: tbl_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				tbl_q[i] <= 8'd0;
		end else if (tbl_we) begin
			tbl_q[ptr_q] <= tbl_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				store_q[i] <= 32'd0;
		end else if (accept && in_opcode == OP_STORE && in_slot < 4'(STORE_DEPTH)) begin
			store_q[in_slot] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= 4'd1;
			ccount_q <= 3'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CORE_MASK:  mask_q   <= cfg_data;
				CFG_CORE_COUNT: ccount_q <= cfg_data[2:0];
				default:        mask_q   <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_opcode;
			chan_q  <= in_channel;
			width_q <= in_width;
			ceil_q  <= in_ceiling;
			adj_q   <= in_adjust;
			bound_q <= in_bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			core_q  <= '0;
			acc_q   <= '0;
			value_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						value_q <= 8'd0;
						ptr_q   <= '0;
						acc_q   <= 8'd0;
						core_q  <= '0;
						case (in_opcode)
							OP_STORE: state_q <= ST_OUT;
							OP_READ: begin
								value_q <= tbl_rd;
								state_q <= ST_OUT;
							end
							OP_LOAD: begin
								acc_q   <= NO_MAX;
								state_q <= ST_CORE;
							end
							OP_SPACING: begin
								acc_q   <= TOP_SPACING;
								count_q <= count_for_width(in_width);
								ptr_q   <= TABLE_AW'(RATES_PER_ROW);
								state_q <= ST_FILL;
							end
							default: begin
								state_q <= (count_q == '0) ? ST_OUT : ST_FILL;
							end
						endcase
					end
				end
				ST_CORE: begin
					if (core_sel)
						acc_q <= alu_y;
					if (core_q == CORE_W'(CORES - 1))
						state_q <= ST_TOP;
					else
						core_q <= core_q + CORE_W'(1);
				end
				ST_TOP: begin
					value_q <= maxp;
					acc_q   <= top;
					count_q <= count_for_width(width_q);
					ptr_q   <= TABLE_AW'(RATES_PER_ROW);
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					if (op_q == OP_LOAD || op_q == OP_SPACING) begin
						ptr_q <= ptr_q + TABLE_AW'(1);
						if (ptr_q == TABLE_AW'(TABLE_SIZE - 1))
							state_q <= ST_LEGACY;
					end else begin
						if (op_q == OP_MAX)
							acc_q <= alu_y;
						if (walk_last) begin
							value_q <= (op_q == OP_MAX) ? alu_y : 8'd0;
							state_q <= ST_OUT;
						end else begin
							ptr_q <= ptr_q + TABLE_AW'(1);
						end
					end
				end
				ST_LEGACY: begin
					ptr_q <= ptr_q + TABLE_AW'(1);
					if (ptr_q == TABLE_AW'(RATES_PER_ROW - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/prtpe_alu.sv
// ----------------------------------------------------------------------------
// prtpe_alu
// Shared per-entry arithmetic: clamped add, min, max and offset subtract.
// ----------------------------------------------------------------------------
module prtpe_alu (
	input  prtpe_pkg::alu_req_t req,
	output logic [7:0]          y
);
	import prtpe_pkg::*;

	logic signed [10:0] sum;
	logic [7:0]         off;

	always_comb begin
		sum = $signed({3'b000, req.a}) + $signed({{2{req.b[8]}}, req.b});
		off = {3'b000, req.b[3:0], 1'b0};
		y   = req.a;
		case (req.mode)
			ALU_ADD: begin
				if (sum < 0)
					y = 8'd0;
				else if (sum > 11'sd127)
					y = 8'd127;
				else
					y = sum[7:0];
			end
			ALU_MIN:  y = (req.a < req.b[7:0]) ? req.a : req.b[7:0];
			ALU_MAX:  y = (req.a > req.b[7:0]) ? req.a : req.b[7:0];
			ALU_SUB2: y = (off > req.a) ? 8'd0 : req.a - off;
			default:  y = req.a;
		endcase
	end

endmodule

>>> rtl/prtpe_chk.sv
// ----------------------------------------------------------------------------
// prtpe_chk
// Port-level checks of the per-rate power table engine, bound to its top.
// ----------------------------------------------------------------------------
`include "per_rate_power_table_engine_defines.svh"

module prtpe_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// One item at a time: no new input while a result is pending.
	`PRTPE_ASSERT_NOW(a_one_item, clk, arst_n, m_tvalid, !s_tready)

	// An input transfer closes the input side until its result is taken.
	`PRTPE_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// The active count only ever takes its reset value or the values a load can set.
	`PRTPE_ASSERT_NOW(a_count_legal, clk, arst_n, m_tvalid,
		m_tdata[13:8] == 6'd0 || m_tdata[13:8] == 6'd16 ||
		m_tdata[13:8] == 6'd24 || m_tdata[13:8] == 6'd32)

	// A stalled result holds.
	`PRTPE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

endmodule

bind per_rate_power_table_engine prtpe_chk u_prtpe_chk (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: per-rate power table engine testbench
// Drives opcode items into the engine and checks every result against a
// predictor of the limit store, the rate table and the entry count. Directed
// items cover reset contents, sub-band and band edges, ceilings, width codes,
// ignored slots and the table operations at their extremes. Random traffic
// then runs under several core selections with stalls on both streams in all but the first phase.
// ----------------------------------------------------------------------------
module tb_top;
	import prtpe_pkg::*;

	// Input item in s_tdata order, highest field first.
	typedef struct packed {
		logic              pad;
		logic [31:0]       slot_word;
		logic [3:0]        slot;
		logic [4:0]        entry_index;
		logic [7:0]        bound;
		logic signed [8:0] adjust;
		logic [7:0]        ceiling;
		logic [1:0]        width_code;
		logic [7:0]        channel;
		logic [2:0]        opcode;
	} power_op_t;

	typedef struct packed {
		logic [1:0] pad;
		logic [5:0] entry_count;
		logic [7:0] value;
	} power_result_t;

	localparam int OFDM_SOURCE [RATES_PER_ROW] = '{0, 0, 0, 0, 1, 2, 3, 4};
	localparam int PHASES = 7;
	localparam logic [3:0] PHASE_MASK  [PHASES] = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd15, 4'd10, 4'd3};
	localparam logic [3:0] PHASE_COUNT [PHASES] = '{4'd4, 4'd4, 4'd4, 4'd2, 4'd0, 4'd3, 4'd1};

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_index = 1'b0;
	logic [3:0]             cfg_data = '0;

	// Predicted engine state.
	logic [31:0] limit_words [STORE_DEPTH] = '{default: '0};
	logic [7:0]  rate_table [TABLE_SIZE] = '{default: '0};
	logic [5:0]  table_count = '0;
	logic [3:0]  core_mask_reg = 4'd1;
	logic [2:0]  core_count_reg = 3'd4;

	power_result_t power_results_q [$];
	bit traffic_idles = 1'b1;
	int fail_count = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int results_checked = 0;
	int settings_used = 1;

	per_rate_power_table_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	// Clears the table, refills the active MCS rows from the offset words of the band and copies the OFDM row.
	function automatic void fill_rate_table(input logic [7:0] chan, input logic [1:0] wcode,
			input logic [7:0] top);
		int band;
		int off;
		logic [31:0] word;
		band = (chan < CHAN_BAND1) ? 0 : ((chan < CHAN_BAND2) ? 1 : 2);
		for (int i = 0; i < TABLE_SIZE; i++) rate_table[i] = '0;
		if (wcode == WIDTH_80) table_count = 6'(4 * RATES_PER_ROW);
		else if (wcode == WIDTH_40) table_count = 6'(3 * RATES_PER_ROW);
		else table_count = 6'(2 * RATES_PER_ROW);
		for (int r = 1; r < 4; r++) begin
			if (r == 1 || int'(table_count) > r * RATES_PER_ROW) begin
				word = limit_words[band * 3 + r - 1];
				for (int i = 0; i < RATES_PER_ROW; i++) begin
					off = 2 * int'(word[4*i +: 4]);
					rate_table[r * RATES_PER_ROW + i] = (off > int'(top)) ? 8'd0 : 8'(int'(top) - off);
				end
			end
		end
		for (int i = 0; i < RATES_PER_ROW; i++)
			rate_table[i] = rate_table[RATES_PER_ROW + OFDM_SOURCE[i]];
	endfunction

	function automatic power_result_t power_engine_step(input power_op_t op);
		power_result_t res;
		logic [7:0] val;
		logic [7:0] maxp;
		logic [7:0] top;
		logic [7:0] m;
		int sb;
		int freq;
		int n;
		int s;
		res = '0;
		val = '0;
		n = (int'(table_count) > TABLE_SIZE) ? TABLE_SIZE : int'(table_count);
		case (op.opcode)
			OP_STORE: begin
				if (op.slot < STORE_DEPTH) limit_words[op.slot] = op.slot_word;
			end
			OP_LOAD: begin
				freq = int'(FREQ_BASE) + 5 * int'(op.channel);
				if (freq < ((op.width_code == WIDTH_40) ? int'(EDGE_LOW40) : int'(EDGE_LOW))) sb = 0;
				else if (freq < int'(EDGE_MID)) sb = 1;
				else if (freq < int'(EDGE_HIGH)) sb = 2;
				else sb = 3;
				maxp = NO_MAX;
				for (int c = 0; c < int'(core_count_reg) && c < CORES_DEF; c++) begin
					if (core_mask_reg[c]) begin
						m = limit_words[CORE_BASE + c][8*sb +: 8];
						if (m < maxp) maxp = m;
					end
				end
				// A minimum still at the "none" marker means no usable maximum.
				if (maxp == NO_MAX) maxp = '0;
				top = (op.ceiling != 0 && op.ceiling < maxp) ? op.ceiling : maxp;
				fill_rate_table(op.channel, op.width_code, top);
				val = maxp;
			end
			OP_SPACING: fill_rate_table(op.channel, op.width_code, TOP_SPACING);
			OP_ADD: begin
				for (int i = 0; i < n; i++) begin
					s = int'(rate_table[i]) + int'(op.adjust);
					if (s < 0) s = 0;
					if (s > 127) s = 127;
					rate_table[i] = 8'(s);
				end
			end
			OP_CAP: begin
				for (int i = 0; i < n; i++)
					if (rate_table[i] > op.bound) rate_table[i] = op.bound;
			end
			OP_FLOOR: begin
				for (int i = 0; i < n; i++)
					if (rate_table[i] < op.bound) rate_table[i] = op.bound;
			end
			OP_MAX: begin
				for (int i = 0; i < n; i++)
					if (rate_table[i] > val) val = rate_table[i];
			end
			default: val = rate_table[op.entry_index];
		endcase
		res.value = val;
		res.entry_count = table_count;
		return res;
	endfunction

	// Item with random content in every field but the pad; callers pin what they test.
	function automatic power_op_t random_op(input logic [2:0] opc);
		power_op_t op;
		op.pad = 1'b0;
		op.opcode = opc;
		op.channel = 8'($urandom_range(0, 255));
		op.width_code = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		op.ceiling = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
		op.adjust = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 510) - 255)
			: 9'($urandom_range(0, 40) - 20);
		op.bound = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(40, 130));
		op.entry_index = 5'($urandom_range(0, 31));
		op.slot = 4'($urandom_range(0, 15));
		op.slot_word = $urandom;
		return op;
	endfunction

	task automatic send_op(input power_op_t op);
		s_tvalid <= 1'b1;
		s_tdata <= op;
		do @(posedge clk); while (!s_tready);
		power_results_q.push_back(power_engine_step(op));
		items_sent++;
		if (op.opcode == OP_LOAD || op.opcode == OP_SPACING) loads_sent++;
		if (traffic_idles && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic send_store(input logic [3:0] slot, input logic [31:0] word);
		power_op_t op;
		op = random_op(OP_STORE);
		op.slot = slot;
		op.slot_word = word;
		send_op(op);
	endtask

	task automatic send_load(input logic [2:0] opc, input logic [7:0] chan,
			input logic [1:0] wcode, input logic [7:0] ceil);
		power_op_t op;
		op = random_op(opc);
		op.channel = chan;
		op.width_code = wcode;
		op.ceiling = ceil;
		send_op(op);
	endtask

	task automatic send_table_op(input logic [2:0] opc, input logic signed [8:0] adj,
			input logic [7:0] bnd, input logic [4:0] idx);
		power_op_t op;
		op = random_op(opc);
		op.adjust = adj;
		op.bound = bnd;
		op.entry_index = idx;
		send_op(op);
	endtask

	// Stops sending and waits until the engine has returned every result.
	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (power_results_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_engine_reg(input logic idx, input logic [3:0] data);
		wait_results_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_CORE_MASK) core_mask_reg = data;
		else core_count_reg = data[2:0];
	endtask

	always @(posedge clk) begin : result_monitor
		power_result_t got;
		power_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (power_results_q.size() == 0) begin
				$error("unexpected result: value %0d, entry_count %0d", got.value, got.entry_count);
				fail_count++;
			end else begin
				want = power_results_q.pop_front();
				results_checked++;
				if (got.value !== want.value) begin
					$error("value: expected %0d, actual %0d", want.value, got.value);
					fail_count++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d", want.entry_count,
						got.entry_count);
					fail_count++;
				end
			end
		end
		m_tready <= traffic_idles ? ($urandom_range(0, 99) >= 6) : 1'b1;
	end

	// Empty table straight out of reset, and a load whose only stored word is an unset core maximum.
	task automatic test_after_reset();
		send_table_op(OP_READ, 9'sd0, 8'd0, 5'd31);
		send_table_op(OP_MAX, 9'sd0, 8'd0, 5'd0);
		send_table_op(OP_ADD, 9'sd255, 8'd0, 5'd0);
		send_store(4'd9, 32'hffff_ffff);
		send_load(OP_LOAD, 8'd36, 2'd0, 8'd0);
	endtask

	// Store words, ignored slots, sub-band edges, bands, ceilings and width codes.
	task automatic test_store_and_load();
		send_store(4'd15, 32'h1234_5678);
		send_store(4'd13, 32'hffff_ffff);
		send_store(4'd0, 32'hffff_ffff);
		send_store(4'd1, 32'h0000_0000);
		send_store(4'd2, 32'h1357_9bdf);
		send_store(4'd9, 32'hfe80_5a3c);
		send_load(OP_LOAD, 8'd42, WIDTH_40, 8'd0);
		send_load(OP_LOAD, 8'd42, 2'd0, 8'd10);
		send_load(OP_LOAD, 8'd50, WIDTH_40, 8'd255);
		send_load(OP_LOAD, 8'd149, WIDTH_80, 8'd0);
		send_load(OP_LOAD, 8'd148, 2'd3, 8'd100);
		send_load(OP_LOAD, 8'd255, WIDTH_80, 8'd1);
	endtask

	// Table operations at their extremes.
	task automatic test_table_ops();
		send_load(OP_SPACING, 8'd0, WIDTH_80, 8'd0);
		send_table_op(OP_ADD, -9'sd255, 8'd0, 5'd0);
		send_load(OP_SPACING, 8'd99, WIDTH_80, 8'd0);
		send_table_op(OP_ADD, 9'sd255, 8'd0, 5'd0);
		send_table_op(OP_FLOOR, 9'sd0, 8'd255, 5'd0);
		send_table_op(OP_MAX, 9'sd0, 8'd0, 5'd0);
		send_table_op(OP_CAP, 9'sd0, 8'd0, 5'd0);
		send_table_op(OP_READ, 9'sd0, 8'd0, 5'd31);
		send_load(OP_SPACING, 8'd52, WIDTH_40, 8'd0);
		send_table_op(OP_READ, 9'sd0, 8'd0, 5'd0);
		send_table_op(OP_READ, 9'sd0, 8'd0, 5'd31);
	endtask

	// No core selected, every selected maximum unset, and partial core counts.
	task automatic test_core_selection();
		write_engine_reg(CFG_CORE_MASK, 4'd0);
		send_load(OP_LOAD, 8'd100, 2'd0, 8'd0);
		send_store(4'd10, 32'hffff_ffff);
		send_store(4'd11, 32'hffff_ffff);
		send_store(4'd12, 32'hffff_ffff);
		send_store(4'd9, 32'hffff_ffff);
		write_engine_reg(CFG_CORE_MASK, 4'd15);
		send_load(OP_LOAD, 8'd60, WIDTH_40, 8'd0);
		send_store(4'd10, 32'h3c5a_7890);
		send_store(4'd11, 32'h2040_ff10);
		write_engine_reg(CFG_CORE_COUNT, 4'd2);
		send_load(OP_LOAD, 8'd120, WIDTH_80, 8'd0);
		write_engine_reg(CFG_CORE_COUNT, 4'd4);
		send_load(OP_LOAD, 8'd160, WIDTH_40, 8'd30);
		settings_used += 3;
	endtask

	// Mostly well-formed traffic: stores feed loads, loads feed table operations.
	task automatic test_random_traffic(input int per_phase);
		power_op_t op;
		int pick;
		for (int p = 0; p < PHASES; p++) begin
			write_engine_reg(CFG_CORE_MASK, PHASE_MASK[p]);
			write_engine_reg(CFG_CORE_COUNT, PHASE_COUNT[p]);
			settings_used++;
			traffic_idles = (p != 0);
			for (int k = 0; k < per_phase; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 18) op = random_op(OP_STORE);
				else if (pick < 32) op = random_op(OP_LOAD);
				else if (pick < 40) op = random_op(OP_SPACING);
				else if (pick < 52) op = random_op(OP_ADD);
				else if (pick < 62) op = random_op(OP_CAP);
				else if (pick < 72) op = random_op(OP_FLOOR);
				else if (pick < 82) op = random_op(OP_MAX);
				else op = random_op(OP_READ);
				// Core words get realistic maxima, with some bytes left unset.
				if (op.opcode == OP_STORE && op.slot >= CORE_BASE && op.slot < STORE_DEPTH) begin
					for (int b = 0; b < 4; b++)
						op.slot_word[8*b +: 8] = ($urandom_range(0, 7) == 0) ? NO_MAX
							: 8'($urandom_range(0, 140));
				end
				send_op(op);
				if (p == 1 && k == per_phase / 2) wait_results_drained();
			end
		end
		traffic_idles = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_after_reset();
		test_store_and_load();
		test_table_ops();
		test_core_selection();
		test_random_traffic(265);
		wait_results_drained();
		repeat (40) @(posedge clk);
		if (power_results_q.size() != 0) begin
			$error("%0d expected results never arrived", power_results_q.size());
			fail_count++;
		end
		$display("Sent %0d items (%0d table loads), checked %0d results.", items_sent,
			loads_sent, results_checked);
		$display("Used %0d core selection settings, with and without stream stalls.",
			settings_used);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
